### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/rpn_pkg.sv
// Package: operation codes, status codes and sizes of the stack machine.
`default_nettype none
package rpn_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int REG_COUNT   = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int RA_W        = $clog2(REG_COUNT);

  localparam logic [4:0] OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_TOP = 5'd2, OP_POP = 5'd3,
    OP_CLEAR = 5'd4, OP_DUP = 5'd5, OP_EXCH = 5'd6, OP_STORE = 5'd7, OP_RECALL = 5'd8,
    OP_ABS = 5'd9, OP_NEG = 5'd10, OP_ADD = 5'd11, OP_SUB = 5'd12, OP_MUL = 5'd13,
    OP_DIV = 5'd14, OP_MOD = 5'd15, OP_NOT = 5'd16, OP_AND = 5'd17, OP_OR = 5'd18,
    OP_XOR = 5'd19, OP_SHL = 5'd20, OP_SHR = 5'd21, OP_INC = 5'd22, OP_DEC = 5'd23,
    OP_HALT = 5'd24;

  localparam logic [2:0] ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_REG = 3'd3,
    ST_DIV0 = 3'd4;

  localparam logic [63:0] LCG_MUL = 64'd1103515245;
  localparam logic [63:0] LCG_ADD = 64'd12345;
  localparam logic [RA_W-1:0] REG_RAND = RA_W'(30);
  localparam logic [RA_W-1:0] REG_TIME = RA_W'(31);

  // Divider request and answer between the top level and the divide unit.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

  function automatic logic [1:0] pops_of(input logic [4:0] op);
    unique case (op)
      OP_POP, OP_TOP, OP_DUP, OP_RECALL, OP_ABS, OP_NEG, OP_NOT, OP_INC, OP_DEC,
      OP_HALT: pops_of = 2'd1;
      OP_EXCH, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
      OP_XOR, OP_SHL, OP_SHR: pops_of = 2'd2;
      default: pops_of = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pushes_of(input logic [4:0] op);
    unique case (op)
      OP_DUP, OP_EXCH: pushes_of = 2'd2;
      OP_PUSH, OP_TOP, OP_RECALL, OP_ABS, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_MOD, OP_NOT, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR, OP_INC,
      OP_DEC: pushes_of = 2'd1;
      default: pushes_of = 2'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

### design/rpn_div.sv
// Iterative signed divider, one quotient bit per cycle.
`default_nettype none
module rpn_div
  import rpn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [63:0] rem_u, quo_u, den_u;
  logic [6:0]  cnt;
  logic        busy, neg_q, neg_r, done_q;
  logic [64:0] trial;

  assign trial = {rem_u, quo_u[63]} - {1'b0, den_u};

  // Restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        cnt   <= 7'd64;
        rem_u <= '0;
        quo_u <= req.num[63] ? 64'(-req.num) : req.num;
        den_u <= req.den[63] ? 64'(-req.den) : req.den;
        neg_q <= req.num[63] ^ req.den[63];
        neg_r <= req.num[63];
      end else if (busy) begin
        if (!trial[64]) begin
          rem_u <= trial[63:0];
          quo_u <= {quo_u[62:0], 1'b1};
        end else begin
          rem_u <= {rem_u[62:0], quo_u[63]};
          quo_u <= {quo_u[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Signs restored on the way out
  assign rsp = '{done: done_q,
                 quo: neg_q ? 64'(-quo_u) : quo_u,
                 rem: neg_r ? 64'(-rem_u) : rem_u};

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_done, clk, rst, busy && cnt == 7'd1, done_q && !busy, "divider did not finish")
  `ASSERT_IMPL(a_div_cnt, clk, rst, busy, cnt != 7'd0, "divider count ran out while busy")
endmodule
`default_nettype wire

### design/rpn_regfile.sv
// Register file memory with valid bits for the all-zero reset.
`default_nettype none
module rpn_regfile
  import rpn_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [RA_W-1:0] raddr,
  output logic [63:0]          rdata,
  input  wire logic            we,
  input  wire logic [RA_W-1:0] waddr,
  input  wire logic [63:0]     wdata
);
  logic [63:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [63:0]          rd_q;
  logic                 rd_valid;

  // Write port and valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_q     <= mem[raddr];
    rd_valid <= valid[raddr] && !rst;
  end

  assign rdata = rd_valid ? rd_q : 64'd0;
endmodule
`default_nettype wire

### design/rpn_stack_machine_alu_core.sv
// Top level: RPN execution unit with stack memory, register file and divider.
`default_nettype none
// One operation per item. After the input transfer the item reads the top operand, reads
// the entry below, executes and commits; the result is registered at the commit. The input
// is ready again in the cycle after the commit, or later when the item writes the stack,
// since the next read waits for that write, and dup or exchange first make their second
// stack write. Multiply adds the states S_MUL1 and S_MUL2 for its 32-bit partial products,
// recall adds S_REGR and S_RAND for the register read (and S_WB2 for register 30 and its
// generator multiply), and div or mod wait in S_DIVW for the bit-serial divider. A result
// still waiting at the output holds the next item in its commit cycle; that item is taken
// and executed meanwhile. The stack lives in a one-read-port synchronous memory, read at
// the two top entries over successive cycles; clear reads the bottom entry. No clearing
// pass after reset.
module rpn_stack_machine_alu_core
  import rpn_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [119:0]  s_tdata,   // operation[4:0], immediate[68:5], now_ms[116:69]
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [79:0]        m_tdata    // value[63:0], status[66:64], depth_after[73:67]
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RDB = 4'd1, S_RDA = 4'd2, S_EXEC = 4'd3,
    S_MUL1 = 4'd4, S_MUL2 = 4'd5, S_DIVW = 4'd6, S_REGR = 4'd7, S_RAND = 4'd8,
    S_WB2 = 4'd9, S_OUT = 4'd10, S_WR2 = 4'd11;

  logic [3:0]       state;
  logic [4:0]       op;
  logic [63:0]      imm, a, b, res;
  logic [47:0]      now;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       status;

  // Stack memory, one port each way
  logic [63:0]     stk [STACK_DEPTH];
  logic [SP_W-1:0] s_raddr, s_waddr;
  logic [63:0]     s_rdata, s_wdata;
  logic            s_we;

  always_ff @(posedge clk) begin
    if (s_we) stk[s_waddr] <= s_wdata;
    s_rdata <= stk[s_raddr];
  end

  // Register file and divider
  logic [63:0] rf_rdata, rf_wdata;
  logic        rf_we;
  logic [RA_W-1:0] rf_waddr;
  div_req_t    dreq;
  div_rsp_t    drsp;

  rpn_regfile u_rf (.clk, .rst, .raddr(b[RA_W-1:0]), .rdata(rf_rdata), .we(rf_we),
                    .waddr(rf_waddr), .wdata(rf_wdata));
  rpn_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  logic [1:0]       p, q;
  logic [CNT_W:0]   n_after;
  logic             reg_bad;
  logic [63:0]      p_ll, p_lh, p_hl;
  logic [CNT_W-1:0] base;
  logic [5:0]       sh;

  assign p       = pops_of(op);
  assign q       = pushes_of(op);
  assign n_after = (CNT_W+1)'(cnt) - (CNT_W+1)'(p) + (CNT_W+1)'(q);
  assign reg_bad = (b[63:RA_W] != '0);
  assign base    = cnt - CNT_W'(p);
  assign sh      = b[5:0];

  // No transfer while a stack write is still on its way to the memory
  assign s_tready = (state == S_IDLE) && !s_we;

  // Read address: top on transfer, below-top while reading operands, bottom for clear
  always_comb begin
    s_raddr = SP_W'(cnt - CNT_W'(1));
    if (state == S_IDLE && s_tvalid && s_tready && s_tdata[4:0] == OP_CLEAR) s_raddr = '0;
    else if (state == S_RDB || state == S_RDA) s_raddr = SP_W'(cnt - CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
      s_we       <= 1'b0;
      rf_we      <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      s_we       <= 1'b0;
      rf_we      <= 1'b0;
      dreq.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          op    <= s_tdata[4:0];
          imm   <= s_tdata[68:5];
          now   <= s_tdata[116:69];
          state <= S_RDB;
        end
        S_RDB: begin
          // s_rdata holds the top (or the bottom for clear)
          b     <= s_rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          // s_rdata now holds the entry below top
          a      <= s_rdata;
          status <= ST_OK;
          res    <= 64'd0;
          state  <= S_OUT;
          if ((CNT_W+1)'(cnt) < (CNT_W+1)'(p)) begin
            status <= ST_UNDER;
          end else if (op != OP_CLEAR && n_after > (CNT_W+1)'(STACK_DEPTH)) begin
            status <= ST_OVER;
          end else begin
            unique case (op)
              OP_PUSH: res <= imm;
              OP_TOP, OP_POP, OP_DUP, OP_HALT: res <= b;
              OP_CLEAR: res <= (cnt != '0) ? b : 64'd0;
              OP_EXCH: res <= s_rdata;
              OP_STORE: if (reg_bad) status <= ST_REG; else res <= s_rdata;
              OP_RECALL: if (reg_bad) status <= ST_REG; else state <= S_REGR;
              OP_ABS: res <= b[63] ? 64'(-b) : b;
              OP_NEG: res <= 64'(-b);
              OP_ADD: res <= s_rdata + b;
              OP_SUB: res <= s_rdata - b;
              OP_MUL: state <= S_MUL1;
              OP_DIV, OP_MOD: begin
                if (b == 64'd0) status <= ST_DIV0;
                else begin
                  dreq.start <= 1'b1;
                  dreq.num   <= s_rdata;
                  dreq.den   <= b;
                  state      <= S_DIVW;
                end
              end
              OP_NOT: res <= ~b;
              OP_AND: res <= s_rdata & b;
              OP_OR:  res <= s_rdata | b;
              OP_XOR: res <= s_rdata ^ b;
              OP_SHL: res <= (b > 64'd63) ? 64'd0 : s_rdata << sh;
              OP_SHR: res <= (b > 64'd63) ? {64{s_rdata[63]}} : 64'($signed(s_rdata) >>> sh);
              OP_INC: res <= b + 64'd1;
              OP_DEC: res <= b - 64'd1;
              default: res <= 64'd0;
            endcase
          end
        end
        S_MUL1: begin
          p_ll  <= a[31:0] * b[31:0];
          p_lh  <= a[31:0] * b[63:32];
          p_hl  <= a[63:32] * b[31:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          res   <= p_ll + {p_lh[31:0] + p_hl[31:0], 32'd0};
          state <= S_OUT;
        end
        S_DIVW: if (drsp.done) begin
          res   <= (op == OP_DIV) ? drsp.quo : drsp.rem;
          state <= S_OUT;
        end
        S_REGR: state <= S_RAND;
        S_RAND: begin
          // rf_rdata valid; 30 and 31 are updated and return the new value instead of the stored one
          if (b[RA_W-1:0] == REG_RAND) begin
            p_ll  <= rf_rdata[31:0] * LCG_MUL[31:0];
            p_lh  <= rf_rdata[63:32] * LCG_MUL[31:0];
            state <= S_WB2;
          end else if (b[RA_W-1:0] == REG_TIME) begin
            res      <= {16'd0, now};
            rf_we    <= 1'b1;
            rf_waddr <= REG_TIME;
            rf_wdata <= {16'd0, now};
            state    <= S_OUT;
          end else begin
            res   <= rf_rdata;
            state <= S_OUT;
          end
        end
        S_WB2: begin
          res      <= p_ll + {p_lh[31:0], 32'd0} + LCG_ADD;
          rf_we    <= 1'b1;
          rf_waddr <= REG_RAND;
          rf_wdata <= p_ll + {p_lh[31:0], 32'd0} + LCG_ADD;
          state    <= S_OUT;
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          // Commit stack and registers, then present the result
          if (status == ST_OK) begin
            if (op == OP_CLEAR) cnt <= '0;
            else cnt <= CNT_W'(n_after);
            if (op == OP_DUP || op == OP_EXCH) begin
              s_we    <= 1'b1;
              s_waddr <= SP_W'(base);
              s_wdata <= b;
            end else if (q == 2'd1) begin
              s_we    <= 1'b1;
              s_waddr <= SP_W'(base);
              s_wdata <= res;
            end
            if (op == OP_STORE) begin
              rf_we    <= 1'b1;
              rf_waddr <= b[RA_W-1:0];
              rf_wdata <= a;
            end
          end
          m_tdata  <= {6'd0, 7'(status == ST_OK ? (op == OP_CLEAR ? '0 : n_after) : cnt),
                       status, status == ST_OK ? res : 64'd0};
          m_tvalid <= 1'b1;
          state    <= (status == ST_OK && (op == OP_DUP || op == OP_EXCH)) ? S_WR2 : S_IDLE;
        end
        S_WR2: begin
          // Second stack write of dup and exchange, one entry above the first
          s_we    <= 1'b1;
          s_waddr <= s_waddr + SP_W'(1);
          s_wdata <= (op == OP_DUP) ? b : a;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `ASSERT_IMPL(a_no_take, clk, rst, s_we, !s_tready, "input taken during a stack write")
endmodule
`default_nettype wire
